// ===== design/mlrp_pkg.sv =====
// shared types, character codes and constants of the methylation line record packer
// used by mlrp_front, mlrp_queue, mlrp_back and the top level; no dependencies
package mlrp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [3:0] FLD_NUC    = 4'd1;
    localparam logic [3:0] FLD_POS    = 4'd2;
    localparam logic [3:0] FLD_CTX    = 4'd3;
    localparam logic [3:0] FLD_DINUC  = 4'd4;
    localparam logic [3:0] FLD_METH   = 4'd6;
    localparam logic [3:0] FLD_TOTAL  = 4'd7;
    localparam logic [3:0] LAST_FIELD = 4'd7;

    localparam logic [2:0] CODE_CA      = 3'd0;
    localparam logic [2:0] CODE_CC      = 3'd2;
    localparam logic [2:0] CODE_CT      = 3'd4;
    localparam logic [2:0] CODE_CG      = 3'd6;
    localparam logic [2:0] CODE_UNKNOWN = 3'd7;

    localparam int          COUNT_BITS  = 14;
    localparam logic [31:0] COUNT_LIMIT = 32'd16383;

    typedef enum logic [1:0] {
        NUM_LEAD,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_NORM,
        BK_SEND
    } back_state_t;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] meth;
        logic [31:0] total;
        logic        strand;
        logic [2:0]  code;
    } rec_t;

    typedef struct packed {
        logic [31:0] acc;
        num_phase_t  phase;
        logic        neg;
    } num_state_t;

endpackage

// ===== design/mlrp_front.sv =====
// line parser: takes one text byte per cycle unless q_full, captures characters and
// decimal fields, pushes one record per line end into the queue; depends on mlrp_pkg
module mlrp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // in_byte
    input  logic               s_tlast,    // last_byte
    input  logic               q_full,
    output logic               q_push,
    output mlrp_pkg::rec_t     q_data
);

    logic [3:0]           fld_reg, fld_next;
    logic [1:0]           chr_reg, chr_next;
    logic [7:0]           nuc_reg, nuc_next;
    logic [7:0]           ctx0_reg, ctx0_next;
    logic [7:0]           ctx2_reg, ctx2_next;
    logic [7:0]           din0_reg, din0_next;
    logic [7:0]           din1_reg, din1_next;
    logic [31:0]          pos_reg, pos_next;
    logic [31:0]          meth_reg, meth_next;
    logic [31:0]          tot_reg, tot_next;
    mlrp_pkg::num_phase_t phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    mlrp_pkg::num_state_t num_res;
    logic                 accept;
    logic                 is_nl;
    logic                 line_end;

    function automatic mlrp_pkg::num_state_t num_step(
        input logic [31:0]          acc,
        input mlrp_pkg::num_phase_t phase,
        input logic                 neg,
        input logic [7:0]           b
    );
        mlrp_pkg::num_state_t r;
        logic                 digit;
        logic                 ws;
        logic                 sign;
        logic [31:0]          t;
        logic [31:0]          d;
        logic                 go;
        r.acc   = acc;
        r.phase = phase;
        r.neg   = neg;
        digit = (b >= mlrp_pkg::CH_ZERO) && (b <= mlrp_pkg::CH_NINE);
        ws    = (b == mlrp_pkg::CH_SPACE) || ((b >= mlrp_pkg::CH_TAB) && (b <= mlrp_pkg::CH_CR));
        sign  = (b == mlrp_pkg::CH_PLUS) || (b == mlrp_pkg::CH_MINUS);
        t     = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
        d     = {24'd0, b - mlrp_pkg::CH_ZERO};
        go    = 1'b0;
        if (phase == mlrp_pkg::NUM_LEAD)
        begin
            if (sign)
            begin
                r.neg   = (b == mlrp_pkg::CH_MINUS);
                r.phase = mlrp_pkg::NUM_DIGITS;
            end
            else if (!ws)
            begin
                go = 1'b1;
            end
        end
        else if (phase == mlrp_pkg::NUM_DIGITS)
        begin
            go = 1'b1;
        end
        if (go)
        begin
            if (digit)
            begin
                r.phase = mlrp_pkg::NUM_DIGITS;
                r.acc   = neg ? (t - d) : (t + d);
            end
            else
            begin
                r.phase = mlrp_pkg::NUM_DONE;
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] ctx_code(
        input logic [7:0] c0,
        input logic [7:0] c2,
        input logic [7:0] d0,
        input logic [7:0] d1
    );
        logic [2:0] g;
        logic [2:0] c;
        g = (c2 == mlrp_pkg::CH_G) ? 3'd1 : 3'd0;
        case (d1)
            mlrp_pkg::CH_A: c = mlrp_pkg::CODE_CA | g;
            mlrp_pkg::CH_C: c = mlrp_pkg::CODE_CC | g;
            mlrp_pkg::CH_T: c = mlrp_pkg::CODE_CT | g;
            mlrp_pkg::CH_G: c = mlrp_pkg::CODE_CG;
            default:        c = mlrp_pkg::CODE_UNKNOWN;
        endcase
        if ((c0 == mlrp_pkg::CH_MINUS) || (d0 == mlrp_pkg::CH_MINUS))
        begin
            c = mlrp_pkg::CODE_UNKNOWN;
        end
        return c;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_nl    = (s_tdata == mlrp_pkg::CH_NL);
    assign line_end = is_nl || s_tlast;
    assign q_push   = accept && line_end;

    always_comb
    begin
        fld_next   = fld_reg;
        chr_next   = chr_reg;
        nuc_next   = nuc_reg;
        ctx0_next  = ctx0_reg;
        ctx2_next  = ctx2_reg;
        din0_next  = din0_reg;
        din1_next  = din1_reg;
        pos_next   = pos_reg;
        meth_next  = meth_reg;
        tot_next   = tot_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;

        case (fld_reg)
            mlrp_pkg::FLD_METH:  num_res = num_step(meth_reg, phase_reg, neg_reg, s_tdata);
            mlrp_pkg::FLD_TOTAL: num_res = num_step(tot_reg, phase_reg, neg_reg, s_tdata);
            default:             num_res = num_step(pos_reg, phase_reg, neg_reg, s_tdata);
        endcase

        if (s_tdata == mlrp_pkg::CH_TAB)
        begin
            if (fld_reg <= mlrp_pkg::LAST_FIELD)
            begin
                fld_next = fld_reg + 4'd1;
            end
            chr_next   = 2'd0;
            phase_next = mlrp_pkg::NUM_LEAD;
            neg_next   = 1'b0;
        end
        else
        begin
            case (fld_reg)
                mlrp_pkg::FLD_NUC:
                begin
                    if (chr_reg == 2'd0)
                    begin
                        nuc_next = s_tdata;
                    end
                end
                mlrp_pkg::FLD_POS:
                begin
                    pos_next   = num_res.acc;
                    phase_next = num_res.phase;
                    neg_next   = num_res.neg;
                end
                mlrp_pkg::FLD_CTX:
                begin
                    if (chr_reg == 2'd0)
                    begin
                        ctx0_next = s_tdata;
                    end
                    else if (chr_reg == 2'd2)
                    begin
                        ctx2_next = s_tdata;
                    end
                end
                mlrp_pkg::FLD_DINUC:
                begin
                    if (chr_reg == 2'd0)
                    begin
                        din0_next = s_tdata;
                    end
                    else if (chr_reg == 2'd1)
                    begin
                        din1_next = s_tdata;
                    end
                end
                mlrp_pkg::FLD_METH:
                begin
                    meth_next  = num_res.acc;
                    phase_next = num_res.phase;
                    neg_next   = num_res.neg;
                end
                mlrp_pkg::FLD_TOTAL:
                begin
                    tot_next   = num_res.acc;
                    phase_next = num_res.phase;
                    neg_next   = num_res.neg;
                end
                default:
                begin
                end
            endcase
            if (chr_reg != 2'd3)
            begin
                chr_next = chr_reg + 2'd1;
            end
        end

        // a newline closes the line as it stands; a last data byte is folded in first
        if (is_nl)
        begin
            q_data.position = pos_reg;
            q_data.meth     = meth_reg;
            q_data.total    = tot_reg;
            q_data.strand   = (nuc_reg == mlrp_pkg::CH_G);
            q_data.code     = ctx_code(ctx0_reg, ctx2_reg, din0_reg, din1_reg);
        end
        else
        begin
            q_data.position = pos_next;
            q_data.meth     = meth_next;
            q_data.total    = tot_next;
            q_data.strand   = (nuc_next == mlrp_pkg::CH_G);
            q_data.code     = ctx_code(ctx0_next, ctx2_next, din0_next, din1_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_reg   <= '0;
            chr_reg   <= '0;
            nuc_reg   <= '0;
            ctx0_reg  <= '0;
            ctx2_reg  <= '0;
            din0_reg  <= '0;
            din1_reg  <= '0;
            pos_reg   <= '0;
            meth_reg  <= '0;
            tot_reg   <= '0;
            phase_reg <= mlrp_pkg::NUM_LEAD;
            neg_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (line_end)
            begin
                fld_reg   <= '0;
                chr_reg   <= '0;
                nuc_reg   <= '0;
                ctx0_reg  <= '0;
                ctx2_reg  <= '0;
                din0_reg  <= '0;
                din1_reg  <= '0;
                pos_reg   <= '0;
                meth_reg  <= '0;
                tot_reg   <= '0;
                phase_reg <= mlrp_pkg::NUM_LEAD;
                neg_reg   <= 1'b0;
            end
            else
            begin
                fld_reg   <= fld_next;
                chr_reg   <= chr_next;
                nuc_reg   <= nuc_next;
                ctx0_reg  <= ctx0_next;
                ctx2_reg  <= ctx2_next;
                din0_reg  <= din0_next;
                din1_reg  <= din1_next;
                pos_reg   <= pos_next;
                meth_reg  <= meth_next;
                tot_reg   <= tot_next;
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
            end
        end
    end

endmodule

// ===== design/mlrp_queue.sv =====
// short record queue between the line parser and the record formatter
// register based ring buffer; depends on mlrp_pkg
module mlrp_queue
#(
    parameter int DEPTH = mlrp_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mlrp_pkg::rec_t push_data,
    input  logic           pop,
    output mlrp_pkg::rec_t pop_data,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mlrp_pkg::rec_t  entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("record pushed into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("record popped from empty queue");
`endif

endmodule

// ===== design/mlrp_back.sv =====
// record formatter: scales the counts one bit per cycle and builds the info word
// holds the finished record in an output register; depends on mlrp_pkg
module mlrp_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  mlrp_pkg::rec_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata     // position, packed_info
);

    mlrp_pkg::back_state_t state_reg, state_next;
    logic [31:0]           pos_reg, pos_next;
    logic [31:0]           mc_reg, mc_next;
    logic [31:0]           tc_reg, tc_next;
    logic                  strand_reg, strand_next;
    logic [2:0]            code_reg, code_next;
    logic [31:0]           info_reg, info_next;
    logic                  load;

    assign m_tvalid = (state_reg == mlrp_pkg::BK_SEND);
    assign m_tdata  = {info_reg, pos_reg};

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        mc_next     = mc_reg;
        tc_next     = tc_reg;
        strand_next = strand_reg;
        code_next   = code_reg;
        info_next   = info_reg;
        load        = 1'b0;
        case (state_reg)
            mlrp_pkg::BK_IDLE:
            begin
                load = !q_empty;
            end
            mlrp_pkg::BK_NORM:
            begin
                if (tc_reg > mlrp_pkg::COUNT_LIMIT)
                begin
                    tc_next = {1'b0, tc_reg[31:1]};
                    mc_next = {1'b0, mc_reg[31:1]};
                end
                else
                begin
                    // the methylated count is not masked, its upper bits merge in
                    info_next  = {strand_reg, code_reg, 28'd0}
                               | {mc_reg[31-mlrp_pkg::COUNT_BITS:0],
                                  mlrp_pkg::COUNT_BITS'(0)}
                               | tc_reg;
                    state_next = mlrp_pkg::BK_SEND;
                end
            end
            mlrp_pkg::BK_SEND:
            begin
                if (m_tready)
                begin
                    load       = !q_empty;
                    state_next = mlrp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mlrp_pkg::BK_IDLE;
            end
        endcase
        if (load)
        begin
            pos_next    = q_data.position;
            mc_next     = q_data.meth;
            tc_next     = q_data.total;
            strand_next = q_data.strand;
            code_next   = q_data.code;
            state_next  = mlrp_pkg::BK_NORM;
        end
        q_pop = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlrp_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        mc_reg     <= mc_next;
        tc_reg     <= tc_next;
        strand_reg <= strand_next;
        code_reg   <= code_next;
        info_reg   <= info_next;
    end

`ifndef SYNTH
    a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlrp_pkg::BK_SEND) |-> (tc_reg <= mlrp_pkg::COUNT_LIMIT))
        else $error("scaled total out of range on output");
    a_halving_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlrp_pkg::BK_NORM) && (tc_reg > mlrp_pkg::COUNT_LIMIT)
        |=> (state_reg == mlrp_pkg::BK_NORM) && (tc_reg == ($past(tc_reg) >> 1)))
        else $error("count scaling step wrong");
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlrp_pkg::BK_SEND) && !m_tready
        |=> (state_reg == mlrp_pkg::BK_SEND) && $stable(m_tdata))
        else $error("formatter moved on while output stalled");
`endif

endmodule

// ===== design/methylation_line_record_packer.sv =====
// top level of the methylation line record packer
// joins mlrp_front, mlrp_queue and mlrp_back; depends on mlrp_pkg
//
// input channel s_*: one text byte per word, s_tlast marks the final byte of the stream
// output channel m_*: one word per line, position in the low half, info word in the high
// a line ends at a newline byte or at a byte marked last (that byte is parsed first)
// the parser takes one byte per cycle while the record queue has room
// records cross a small queue (QUEUE_DEPTH entries) to the formatter
// the formatter pops a record, halves both counts once per cycle until the
// total is at most 16383, then presents the word; while records are waiting,
// the next record is popped as the word is taken, else the formatter goes idle
// when m_tready is low the word holds, the queue fills and s_tready drops
// reset clears the parser state, empties the queue and drops m_tvalid
module methylation_line_record_packer
#(
    parameter int QUEUE_DEPTH = mlrp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // position, packed_info
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    mlrp_pkg::rec_t q_in;
    mlrp_pkg::rec_t q_out;

    mlrp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    mlrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    mlrp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
